// ===== rtl/m4i_pkg.sv =====
// Shared types, constants and helpers for the 4x4 matrix inverse block.
// No dependencies; every other file uses this package.
`default_nettype none
package m4i_pkg;

    localparam int DIM        = 4;
    localparam int CELLS      = DIM * DIM;
    localparam int IDX_W      = $clog2(CELLS);
    localparam int POS_W      = $clog2(DIM);
    localparam int DATA_W     = 32;
    localparam int COF_W      = 48;
    localparam int CSUM_W     = 50;
    localparam int DTERM_W    = 60;
    localparam int DET_W      = 62;
    localparam int OPND_W     = 64;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int CHUNK_W    = 16;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        OP_M1,
        OP_M2,
        OP_TERM,
        OP_DET,
        OP_INV
    } t_op;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_GO,
        ST_WAIT,
        ST_CWR,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             mat_we;
        logic [IDX_W-1:0] mat_wa;
        logic             rd_en;
        logic [IDX_W-1:0] mat_ra;
        logic [IDX_W-1:0] mat_rb;
        logic [IDX_W-1:0] cof_ra;
        t_op              op;
        logic             mul_start;
        logic             term_neg;
        logic             cof_we;
        logic [IDX_W-1:0] cof_wa;
        logic             cof_neg;
        logic             clr_run;
        logic             div_start;
        logic             out_valid;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic singular;
    } t_stat;

    // n-th index of 0..3 that skips index ex (n in 0..2)
    function automatic logic [POS_W-1:0] skip_idx(input logic [POS_W-1:0] ex,
                                                  input logic [POS_W-1:0] n);
        return (n >= ex) ? n + POS_W'(1) : n;
    endfunction

    // True when v fits a signed field of the given width
    function automatic logic fits_s(input logic signed [PROD_W-1:0] v,
                                    input int unsigned bits);
        logic signed [PROD_W-1:0] lim;
        lim = PROD_W'(1) << (bits - 1);
        return (v < lim) && (v >= -lim);
    endfunction

    // Clip v to a signed field of the given width
    function automatic logic signed [PROD_W-1:0] clip_s(input logic signed [PROD_W-1:0] v,
                                                        input int unsigned bits);
        logic signed [PROD_W-1:0] lim;
        lim = PROD_W'(1) << (bits - 1);
        if (v >= lim) begin
            return lim - PROD_W'(1);
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/m4i_mul.sv =====
// Sequential signed multiplier: 64 x 64 bits, one 64 x 16 partial product per cycle.
// Depends on m4i_pkg.
`default_nettype none
module m4i_mul (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [m4i_pkg::OPND_W-1:0]     i_a,
    input  wire logic signed [m4i_pkg::OPND_W-1:0]     i_b,
    output logic                                       o_done,
    output logic signed [m4i_pkg::PROD_W-1:0]          o_prod
);
    import m4i_pkg::*;

    localparam int CHUNKS = OPND_W / CHUNK_W;
    localparam int CNT_W  = $clog2(CHUNKS);
    localparam int PART_W = OPND_W + CHUNK_W;

    logic [OPND_W-1:0]        r_ua;
    logic [OPND_W-1:0]        r_ub;
    logic [PROD_W-1:0]        r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_fin;
    logic                     r_neg;
    logic                     r_done;
    logic signed [PROD_W-1:0] r_prod;
    logic [PART_W-1:0]        w_part;

    // Top chunk of the multiplier magnitude times the full multiplicand
    assign w_part = PART_W'(r_ua) * PART_W'(r_ub[OPND_W-1 -: CHUNK_W]);

    // Control: run CHUNKS steps, then one sign-fix step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitudes in, shift-accumulate, negate at the end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[OPND_W-1] ? OPND_W'(-i_a) : OPND_W'(i_a);
            r_ub  <= i_b[OPND_W-1] ? OPND_W'(-i_b) : OPND_W'(i_b);
            r_neg <= i_a[OPND_W-1] ^ i_b[OPND_W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PROD_W'(w_part);
            r_ub  <= {r_ub[OPND_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
        end
        if (r_fin) begin
            r_prod <= r_neg ? -$signed(r_acc) : $signed(r_acc);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== rtl/m4i_div.sv =====
// Restoring divider for the reciprocal 2^(2F) / |det|, one quotient bit per cycle.
// Depends on m4i_pkg.
`default_nettype none
module m4i_div #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [m4i_pkg::DET_W-1:0]         i_divisor,
    output logic                                   o_done,
    output logic [m4i_pkg::OPND_W-1:0]             o_quot
);
    import m4i_pkg::*;

    localparam int QW    = 2 * FRAC_BITS + 1;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int REM_W = DET_W + 1;

    logic [DET_W-1:0] r_d;
    logic [REM_W-1:0] r_rem;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W-1:0] w_rem_sh;
    logic             w_ge;

    // Dividend is a single one at bit 2F, fed first
    assign w_rem_sh = {r_rem[REM_W-2:0], (r_cnt == CNT_W'(QW))};
    assign w_ge     = w_rem_sh >= REM_W'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sh - REM_W'(r_d) : w_rem_sh;
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = OPND_W'(r_q);

endmodule
`default_nettype wire

// ===== rtl/m4i_datapath.sv =====
// Datapath: matrix and cofactor memories, shared multiplier, divider, accumulators.
// Depends on m4i_pkg, m4i_mul and m4i_div.
`default_nettype none
module m4i_datapath #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire m4i_pkg::t_cmd                         i_cmd,
    input  wire logic signed [m4i_pkg::DATA_W-1:0]     i_element_value,
    output m4i_pkg::t_stat                             o_stat,
    output logic signed [m4i_pkg::DATA_W-1:0]          o_inverse_value,
    output logic signed [m4i_pkg::DATA_W-1:0]          o_det_value,
    output logic                                       o_singular_flag,
    output logic                                       o_saturated_flag
);
    import m4i_pkg::*;

    logic signed [DATA_W-1:0] r_mat [CELLS];
    logic signed [COF_W-1:0]  r_cof [CELLS];
    logic signed [DATA_W-1:0] r_rda;
    logic signed [DATA_W-1:0] r_rdb;
    logic signed [COF_W-1:0]  r_rdc;
    logic signed [OPND_W-1:0] r_t;
    logic signed [OPND_W-1:0] r_minor;
    logic signed [CSUM_W-1:0] r_csum;
    logic signed [DET_W-1:0]  r_det;
    logic signed [OPND_W-1:0] r_recip;
    logic signed [DATA_W-1:0] r_val;
    logic                     r_eclip;
    logic                     r_clip;

    logic signed [OPND_W-1:0] w_a;
    logic signed [OPND_W-1:0] w_b;
    logic                     w_mul_done;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_sh;
    logic signed [OPND_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_p48;
    logic signed [PROD_W-1:0] w_cs;
    logic signed [PROD_W-1:0] w_det_x;
    logic                     w_div_done;
    logic [OPND_W-1:0]        w_quot;
    logic [DET_W-1:0]         w_det_mag;
    logic                     w_singular;
    logic                     w_det_fits;

    // Memories: one write port each, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_we) begin
            r_mat[i_cmd.mat_wa] <= i_element_value;
        end
        if (i_cmd.cof_we) begin
            r_cof[i_cmd.cof_wa] <= COF_W'(clip_s(w_cs, COF_W));
        end
        if (i_cmd.rd_en) begin
            r_rda <= r_mat[i_cmd.mat_ra];
            r_rdb <= r_mat[i_cmd.mat_rb];
            r_rdc <= r_cof[i_cmd.cof_ra];
        end
    end

    // Select multiplier operands by operation
    always_comb begin
        w_a = OPND_W'(r_rda);
        w_b = OPND_W'(r_rdb);
        case (i_cmd.op)
            OP_TERM: w_b = r_minor;
            OP_DET:  w_b = OPND_W'(r_rdc);
            OP_INV: begin
                w_a = OPND_W'(r_rdc);
                w_b = r_recip;
            end
            default: ;
        endcase
    end

    m4i_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_det_mag = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);

    m4i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (w_det_mag),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // Floor shift of the product, minor difference, term and cofactor sums
    assign w_sh    = w_prod >>> FRAC_BITS;
    assign w_diff  = r_t - w_prod[OPND_W-1:0];
    assign w_p48   = clip_s(w_sh, COF_W);
    assign w_cs    = i_cmd.cof_neg ? -PROD_W'(r_csum) : PROD_W'(r_csum);
    assign w_det_x = PROD_W'(r_det);

    // Apply each finished product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
            r_csum <= '0;
            r_det  <= '0;
        end else if (i_cmd.clr_run) begin
            r_clip <= 1'b0;
            r_csum <= '0;
            r_det  <= '0;
        end else begin
            if (i_cmd.cof_we) begin
                r_csum <= '0;
                if (!fits_s(w_cs, COF_W)) begin
                    r_clip <= 1'b1;
                end
            end
            if (w_mul_done) begin
                case (i_cmd.op)
                    OP_TERM: begin
                        r_csum <= i_cmd.term_neg ? r_csum - CSUM_W'(w_p48)
                                                 : r_csum + CSUM_W'(w_p48);
                        if (!fits_s(w_sh, COF_W)) begin
                            r_clip <= 1'b1;
                        end
                    end
                    OP_DET: begin
                        r_det <= r_det + DET_W'(clip_s(w_sh, DTERM_W));
                        if (!fits_s(w_sh, DTERM_W)) begin
                            r_clip <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers of the sequence
    always_ff @(posedge i_clk) begin
        if (w_mul_done) begin
            case (i_cmd.op)
                OP_M1:   r_t     <= w_prod[OPND_W-1:0];
                OP_M2:   r_minor <= w_diff >>> FRAC_BITS;
                OP_INV: begin
                    r_val   <= DATA_W'(clip_s(w_sh, DATA_W));
                    r_eclip <= !fits_s(w_sh, DATA_W);
                end
                default: ;
            endcase
        end
        if (w_div_done) begin
            r_recip <= r_det[DET_W-1] ? -$signed(w_quot) : $signed(w_quot);
        end
    end

    assign w_singular = (r_det == '0);
    assign w_det_fits = fits_s(w_det_x, DATA_W);

    assign o_stat.mul_done = w_mul_done;
    assign o_stat.div_done = w_div_done;
    assign o_stat.singular = w_singular;

    assign o_inverse_value  = w_singular ? '0 : r_val;
    assign o_det_value      = DATA_W'(clip_s(w_det_x, DATA_W));
    assign o_singular_flag  = w_singular;
    assign o_saturated_flag = r_clip | !w_det_fits | (!w_singular & r_eclip);

endmodule
`default_nettype wire

// ===== rtl/m4i_ctrl.sv =====
// Controller: load counter and the cofactor, determinant, divide and output sequence.
// Depends on m4i_pkg.
`default_nettype none
module m4i_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire m4i_pkg::t_stat  i_stat,
    output m4i_pkg::t_cmd        o_cmd
);
    import m4i_pkg::*;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_q, n_q;
    logic [POS_W-1:0] r_k, n_k;

    logic [POS_W-1:0] w_r, w_c;
    logic [POS_W-1:0] w_sr0, w_sr1, w_sr2;
    logic [POS_W-1:0] w_sck, w_sca, w_scb;

    // Submatrix rows and the columns of the current term
    always_comb begin
        w_r   = r_q[IDX_W-1 -: POS_W];
        w_c   = r_q[POS_W-1:0];
        w_sr0 = skip_idx(w_r, POS_W'(0));
        w_sr1 = skip_idx(w_r, POS_W'(1));
        w_sr2 = skip_idx(w_r, POS_W'(2));
        w_sck = skip_idx(w_c, r_k);
        w_sca = skip_idx(w_c, (r_k == POS_W'(0)) ? POS_W'(1) : POS_W'(0));
        w_scb = skip_idx(w_c, (r_k == POS_W'(2)) ? POS_W'(1) : POS_W'(2));
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_op    <= OP_M1;
            r_cnt   <= '0;
            r_q     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
            r_q     <= n_q;
            r_k     <= n_k;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_k     = r_k;

        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.mat_wa    = r_cnt;
        o_cmd.cof_ra    = r_q;
        o_cmd.cof_wa    = r_q;
        o_cmd.term_neg  = r_k[0];
        o_cmd.cof_neg   = w_r[0] ^ w_c[0];
        o_cmd.out_row   = w_r;
        o_cmd.out_col   = w_c;
        o_cmd.out_last  = (r_q == IDX_W'(CELLS - 1));
        busy            = (r_state != ST_LOAD);

        case (r_op)
            OP_M1: begin
                o_cmd.mat_ra = {w_sr1, w_sca};
                o_cmd.mat_rb = {w_sr2, w_scb};
            end
            OP_M2: begin
                o_cmd.mat_ra = {w_sr1, w_scb};
                o_cmd.mat_rb = {w_sr2, w_sca};
            end
            OP_TERM: o_cmd.mat_ra = {w_sr0, w_sck};
            OP_DET:  o_cmd.mat_ra = r_q;
            OP_INV:  o_cmd.cof_ra = {w_c, w_r};
            default: ;
        endcase

        unique case (r_state)
            ST_LOAD: begin
                if (start) begin
                    o_cmd.mat_we = 1'b1;
                    n_cnt = r_cnt + IDX_W'(1);
                    if (r_cnt == IDX_W'(CELLS - 1)) begin
                        o_cmd.clr_run = 1'b1;
                        n_q     = '0;
                        n_k     = '0;
                        n_op    = OP_M1;
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = ST_GO;
            end
            ST_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = ST_RD;
                    case (r_op)
                        OP_M1: n_op = OP_M2;
                        OP_M2: n_op = OP_TERM;
                        OP_TERM: begin
                            if (r_k == POS_W'(2)) begin
                                n_state = ST_CWR;
                            end else begin
                                n_k  = r_k + POS_W'(1);
                                n_op = OP_M1;
                            end
                        end
                        OP_DET: begin
                            if (r_q == IDX_W'(DIM - 1)) begin
                                n_q     = '0;
                                n_state = ST_DIV_GO;
                            end else begin
                                n_q = r_q + IDX_W'(1);
                            end
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_CWR: begin
                o_cmd.cof_we = 1'b1;
                n_state = ST_RD;
                n_k     = '0;
                if (r_q == IDX_W'(CELLS - 1)) begin
                    n_q  = '0;
                    n_op = OP_DET;
                end else begin
                    n_q  = r_q + IDX_W'(1);
                    n_op = OP_M1;
                end
            end
            ST_DIV_GO: begin
                n_op = OP_INV;
                if (i_stat.singular) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_RD;
                end
            end
            ST_OUT: begin
                o_cmd.out_valid = 1'b1;
                if (r_q == IDX_W'(CELLS - 1)) begin
                    n_q     = '0;
                    n_state = ST_LOAD;
                end else begin
                    n_q     = r_q + IDX_W'(1);
                    n_state = i_stat.singular ? ST_OUT : ST_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/matrix4x4_inverse.sv =====
// Top level of the 4x4 fixed-point matrix inverse (adjugate over determinant).
// Depends on m4i_pkg, m4i_ctrl and m4i_datapath.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  input   | start / busy       | i_element_value
//  result  | o_valid (strobe)   | o_inverse_value o_out_row o_out_col o_det_value
//          |                    | o_singular_flag o_saturated_flag o_last_of_run
//
// Fifteen elements are taken one per cycle with no result. The sixteenth starts
// the solve: 144 products on one 64x16-per-cycle multiplier, 16 cofactor
// writes, 4 determinant products, a divide and 16 more products with one strobe
// cycle each; a singular matrix skips the divide and those products and gives
// its 16 strobes back to back. The solve is paced by the shared multiplier.
// Results leave one per strobe cycle; the receiver cannot stall them. busy is
// high from the cycle after the sixteenth element until the last result. Reset
// is synchronous and clears the sequencer and load count.
`default_nettype none
module matrix4x4_inverse #(
    parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [m4i_pkg::DATA_W-1:0] i_element_value,
    output logic                                   o_valid,
    output logic signed [m4i_pkg::DATA_W-1:0]      o_inverse_value,
    output logic [m4i_pkg::POS_W-1:0]              o_out_row,
    output logic [m4i_pkg::POS_W-1:0]              o_out_col,
    output logic signed [m4i_pkg::DATA_W-1:0]      o_det_value,
    output logic                                   o_singular_flag,
    output logic                                   o_saturated_flag,
    output logic                                   o_last_of_run
);
    import m4i_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    m4i_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    m4i_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_element_value  (i_element_value),
        .o_stat           (w_stat),
        .o_inverse_value  (o_inverse_value),
        .o_det_value      (o_det_value),
        .o_singular_flag  (o_singular_flag),
        .o_saturated_flag (o_saturated_flag)
    );

    // Result strobe and position
    assign o_valid       = w_cmd.out_valid;
    assign o_out_row     = w_cmd.out_row;
    assign o_out_col     = w_cmd.out_col;
    assign o_last_of_run = w_cmd.out_valid & w_cmd.out_last;

endmodule
`default_nettype wire

// ===== rtl/m4i_checker.sv =====
// Port-level checks for matrix4x4_inverse, bound to the top level.
// Depends on m4i_pkg and matrix4x4_inverse.
`default_nettype none
module m4i_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              busy,
    input wire logic                              o_valid,
    input wire logic signed [m4i_pkg::DATA_W-1:0] o_inverse_value,
    input wire logic [m4i_pkg::POS_W-1:0]         o_out_row,
    input wire logic [m4i_pkg::POS_W-1:0]         o_out_col,
    input wire logic                              o_singular_flag,
    input wire logic                              o_last_of_run
);
    // A result transaction only appears during a solve
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe while idle");

    // The final result sits at the last position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_run |-> (o_valid && o_out_row == 2'd3 && o_out_col == 2'd3))
        else $error("last result at wrong position");

    // A singular matrix gives zero elements
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular_flag) |-> (o_inverse_value == '0))
        else $error("nonzero element for singular matrix");

    // The block goes idle right after the last result
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_run |=> !busy) else $error("busy after last result");

    // Reset returns the block to idle
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy) else $error("busy after reset");

endmodule

bind matrix4x4_inverse m4i_checker u_m4i_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_inverse_value (o_inverse_value),
    .o_out_row       (o_out_row),
    .o_out_col       (o_out_col),
    .o_singular_flag (o_singular_flag),
    .o_last_of_run   (o_last_of_run)
);
`default_nettype wire

// ===== sim/tb_matrix4x4_inverse.sv =====
// Self-checking testbench for matrix4x4_inverse: loads 4x4 Q16.16 matrices,
// predicts the adjugate-based inverse in a scoreboard class and checks results.
// Depends on m4i_pkg and the matrix4x4_inverse RTL.
`default_nettype none
module tb_matrix4x4_inverse;
    import m4i_pkg::*;

    localparam int FRAC        = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        logic signed [DATA_W-1:0] inv;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [DATA_W-1:0] det;
        logic                     singular;
        logic                     sat;
        logic                     last;
    } t_inv_elem;

    typedef logic signed [127:0] t_wide;

    // Tracks loaded matrices and holds the predicted inverse elements
    class inverse_scoreboard;
        t_wide       mat[CELLS];
        t_wide       cof[CELLS];
        int unsigned load_idx = 0;
        t_inv_elem   inv_q[$];
        int          errors = 0;

        function t_wide sat_s(t_wide v, int bits, inout bit clip);
            t_wide lim;
            lim = t_wide'(1) <<< (bits - 1);
            if (v >= lim) begin
                clip = 1;
                return lim - 1;
            end
            if (v < -lim) begin
                clip = 1;
                return -lim;
            end
            return v;
        endfunction

        function t_wide cofactor(int r, int c, inout bit clip);
            t_wide s[3][3];
            t_wide m0, m1, m2, sum;
            int dr, dc;
            dr = 0;
            for (int sr = 0; sr < DIM; sr++) begin
                if (sr == r) continue;
                dc = 0;
                for (int sc = 0; sc < DIM; sc++) begin
                    if (sc == c) continue;
                    s[dr][dc] = mat[sr * DIM + sc];
                    dc++;
                end
                dr++;
            end
            m0 = (s[1][1] * s[2][2] - s[1][2] * s[2][1]) >>> FRAC;
            m1 = (s[1][0] * s[2][2] - s[1][2] * s[2][0]) >>> FRAC;
            m2 = (s[1][0] * s[2][1] - s[1][1] * s[2][0]) >>> FRAC;
            sum = sat_s((s[0][0] * m0) >>> FRAC, COF_W, clip)
                - sat_s((s[0][1] * m1) >>> FRAC, COF_W, clip)
                + sat_s((s[0][2] * m2) >>> FRAC, COF_W, clip);
            if ((r + c) % 2 == 1) sum = -sum;
            return sat_s(sum, COF_W, clip);
        endfunction

        // Record one accepted element; the sixteenth solves the matrix
        function void note_element(logic signed [DATA_W-1:0] v);
            bit        clip, eclip, singular;
            t_wide     det, det_out, recip, val;
            t_inv_elem e;
            mat[load_idx] = t_wide'(v);
            if (load_idx != CELLS - 1) begin
                load_idx++;
                return;
            end
            load_idx = 0;
            clip = 0;
            for (int k = 0; k < CELLS; k++) cof[k] = cofactor(k / DIM, k % DIM, clip);
            det = 0;
            for (int j = 0; j < DIM; j++)
                det += sat_s((mat[j] * cof[j]) >>> FRAC, DTERM_W, clip);
            det_out = sat_s(det, DATA_W, clip);
            singular = (det == 0);
            recip = singular ? t_wide'(0) : (t_wide'(1) <<< (2 * FRAC)) / det;
            for (int k = 0; k < CELLS; k++) begin
                eclip = 0;
                val = 0;
                if (!singular)
                    val = sat_s((cof[(k % DIM) * DIM + k / DIM] * recip) >>> FRAC,
                                DATA_W, eclip);
                e.inv      = val[DATA_W-1:0];
                e.row      = POS_W'(k / DIM);
                e.col      = POS_W'(k % DIM);
                e.det      = det_out[DATA_W-1:0];
                e.singular = singular;
                e.sat      = eclip || clip;
                e.last     = (k == CELLS - 1);
                inv_q.push_back(e);
            end
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_result(t_inv_elem got);
            t_inv_elem want;
            if (inv_q.size() == 0) begin
                $display("%0t: unexpected result inv=%h row=%0d col=%0d", $time,
                         got.inv, got.row, got.col);
                errors++;
                return;
            end
            want = inv_q.pop_front();
            if (got.inv !== want.inv) begin
                $display("%0t: inverse_value exp %h got %h", $time, want.inv, got.inv);
                errors++;
            end
            if (got.row !== want.row) begin
                $display("%0t: out_row exp %0d got %0d", $time, want.row, got.row);
                errors++;
            end
            if (got.col !== want.col) begin
                $display("%0t: out_col exp %0d got %0d", $time, want.col, got.col);
                errors++;
            end
            if (got.det !== want.det) begin
                $display("%0t: det_value exp %h got %h", $time, want.det, got.det);
                errors++;
            end
            if (got.singular !== want.singular) begin
                $display("%0t: singular_flag exp %b got %b", $time, want.singular,
                         got.singular);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated_flag exp %b got %b", $time, want.sat, got.sat);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_of_run exp %b got %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 0;
    logic                     i_rst_n = 0;
    logic                     start = 0;
    logic signed [DATA_W-1:0] i_element_value = '0;
    logic                     busy;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_inverse_value;
    logic [POS_W-1:0]         o_out_row;
    logic [POS_W-1:0]         o_out_col;
    logic signed [DATA_W-1:0] o_det_value;
    logic                     o_singular_flag;
    logic                     o_saturated_flag;
    logic                     o_last_of_run;

    inverse_scoreboard inv_sb = new();
    int unsigned       cycle_count = 0;

    matrix4x4_inverse #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_element_value(i_element_value), .o_valid(o_valid),
        .o_inverse_value(o_inverse_value), .o_out_row(o_out_row),
        .o_out_col(o_out_col), .o_det_value(o_det_value),
        .o_singular_flag(o_singular_flag), .o_saturated_flag(o_saturated_flag),
        .o_last_of_run(o_last_of_run)
    );

    always #10 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("matrix4x4_inverse: mismatch");
            $finish;
        end
    end

    // Capture result strobes
    always @(posedge i_clk) begin
        t_inv_elem got;
        if (i_rst_n && o_valid) begin
            got.inv      = o_inverse_value;
            got.row      = o_out_row;
            got.col      = o_out_col;
            got.det      = o_det_value;
            got.singular = o_singular_flag;
            got.sat      = o_saturated_flag;
            got.last     = o_last_of_run;
            inv_sb.check_result(got);
        end
    end

    // Drive one element transaction, then an optional random gap
    task automatic send_element(input logic signed [DATA_W-1:0] v);
        int gap, pick;
        start <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (busy);
        inv_sb.note_element(v);
        pick = $urandom_range(0, 99);
        if (pick < 55) gap = 0;
        else if (pick < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 120);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (inv_sb.inv_q.size() != 0) @(posedge i_clk);
    endtask

    // Diagonal matrix with a given diagonal value
    task automatic send_diag(input logic signed [DATA_W-1:0] d);
        for (int k = 0; k < CELLS; k++) send_element((k % 5 == 0) ? d : '0);
    endtask

    initial begin
        int kind;
        logic signed [DATA_W-1:0] row0[DIM];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, zero, tiny and huge diagonals, all minimum
        send_diag(32'sh0001_0000);
        for (int k = 0; k < CELLS; k++) send_element('0);
        send_diag(32'sh0000_0001);
        send_diag(32'sh7fff_ffff);
        for (int k = 0; k < CELLS; k++) send_element(32'sh8000_0000);

        // Random matrices
        for (int m = 0; m < 8; m++) begin
            if (m == 4) begin
                start <= 1'b0;
                wait_drained();
                @(posedge i_clk);
            end
            kind = $urandom_range(0, 9);
            for (int k = 0; k < CELLS; k++) begin
                if (kind < 5) begin
                    // well conditioned: dominant diagonal, small off-diagonal
                    if (k % 5 == 0)
                        send_element(DATA_W'($urandom_range(32'h0001_0000, 32'h0004_0000)));
                    else
                        send_element(DATA_W'(int'($urandom_range(0, 32'h0000_8000))
                                             - 32'sh0000_4000));
                end else if (kind < 8) begin
                    send_element(DATA_W'($urandom));
                end else begin
                    // repeated first row makes the matrix singular
                    if (k < DIM) row0[k] = DATA_W'($urandom_range(0, 32'h0003_ffff));
                    send_element((k >= 2 * DIM && k < 3 * DIM) ? row0[k % DIM]
                                 : (k < DIM ? row0[k] : DATA_W'($urandom)));
                end
            end
        end
        start <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (inv_sb.errors == 0 && inv_sb.inv_q.size() == 0) begin
            $display("matrix4x4_inverse: match");
        end else begin
            $display("matrix4x4_inverse: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
